/* rtl/core/lmv_pkg.sv */
// Shared constants and types for the LRU/MRU victim list.
`timescale 1ns / 1ps
`default_nettype none
package lmv_pkg;

  localparam int LIST_ENTRIES_DEF = 64;

  localparam int PAGE_W = 32;
  localparam int PIN_W  = 16;

  // command codes
  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_TOUCH    = 3'd1;
  localparam logic [2:0] CMD_REMOVE   = 3'd2;
  localparam logic [2:0] CMD_PICK_ONE = 3'd3;
  localparam logic [2:0] CMD_PICK_BAT = 3'd4;
  localparam logic [2:0] CMD_SET_PIN  = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_VICTIM = 2'd1;
  localparam logic [1:0] STAT_NONE   = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ORDER = 2'd0;
  localparam logic [1:0] CFG_WMODE = 2'd1;
  localparam logic [1:0] CFG_KEEP  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD,
    CELL_PIN
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [PAGE_W-1:0]   page;
    logic [PIN_W-1:0]    pins;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/lru_mru_victim_list.sv */
// Top level of the LRU/MRU victim list: cell row, command sequencer, output register.
`timescale 1ns / 1ps
`default_nettype none
// Recency list of up to LIST_ENTRIES page ids kept in a row of cells, oldest at
// cell 0. Add, touch, remove, set pin count and the unused codes are accepted,
// then do one update of the whole row, during which touch and remove shift the
// entries above the hit down by one cell. Pick one and pick batch are accepted,
// then a scan counter walks the list one entry a cycle, waiting at a victim
// while the output register is still full, and stops at the first victim or,
// for an LRU batch with write mode clear, at the keep threshold or the last
// unpinned entry. With no unpinned entry the whole list is examined, then the
// no-victim result is given. A result sits in an output register; the sequencer
// stalls only when that register is still full. One request is worked at a
// time, so a request is taken only once the previous one has produced its final
// result. Configuration writes are taken at any time and belong between requests.
module lru_mru_victim_list #(
  parameter int LIST_ENTRIES = lmv_pkg::LIST_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] page_id,
  input  wire logic [15:0] pin_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      victim_page,
  output logic [1:0]       status,
  output logic             last
);

  localparam int CNT_W = $clog2(LIST_ENTRIES + 1);
  localparam int IDX_W = $clog2(LIST_ENTRIES);
  localparam int THR_W = CNT_W + 9;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state, state_next;

  logic             replacement_order;
  logic             write_mode;
  logic [7:0]       keep_fraction;

  logic [2:0]       cmd_q;
  logic [31:0]      page_q;
  logic [15:0]      pins_q;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] scan_n;
  logic [CNT_W-1:0] found;
  logic [THR_W-1:0] thresh;

  lmv_pkg::cell_ctrl_t ctrl [LIST_ENTRIES];
  logic [31:0] cell_page [LIST_ENTRIES];
  logic [15:0] cell_pins [LIST_ENTRIES];
  logic        cell_hit  [LIST_ENTRIES];
  logic        cell_zero [LIST_ENTRIES];
  logic        in_list   [LIST_ENTRIES];
  logic        elig      [LIST_ENTRIES];

  // ---------------- cell row ----------------
  for (genvar g = 0; g < LIST_ENTRIES; g++) begin : g_cell
    if (g == LIST_ENTRIES - 1) begin : g_end
      lmv_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[g]),
        .nxt_page (cell_page[g]),
        .nxt_pins (cell_pins[g]),
        .page     (cell_page[g]),
        .pins     (cell_pins[g]),
        .hit      (cell_hit[g]),
        .zero     (cell_zero[g])
      );
    end else begin : g_mid
      lmv_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[g]),
        .nxt_page (cell_page[g+1]),
        .nxt_pins (cell_pins[g+1]),
        .page     (cell_page[g]),
        .pins     (cell_pins[g]),
        .hit      (cell_hit[g]),
        .zero     (cell_zero[g])
      );
    end
  end

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_order <= 1'b0;
      write_mode        <= 1'b0;
      keep_fraction     <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lmv_pkg::CFG_ORDER: replacement_order <= cfg_data[0];
        lmv_pkg::CFG_WMODE: write_mode        <= cfg_data[0];
        lmv_pkg::CFG_KEEP:  keep_fraction     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------- match and scan decode ----------------
  logic             hit_any;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] tail;
  logic             full;
  logic [15:0]      keep_pins;
  logic [CNT_W-1:0] idx_c;
  logic [IDX_W-1:0] idx;
  logic             more_after;
  logic             cur_elig;
  logic             scan_end;
  logic [CNT_W-1:0] found_inc;
  logic             thr_hit;
  logic             stop_one;
  logic             vic_last;
  logic             out_free;

  always_comb begin
    hit_any = 1'b0;
    pos     = '0;
    for (int i = LIST_ENTRIES - 1; i >= 0; i--) begin
      in_list[i] = (CNT_W'(i) < cnt);
      elig[i]    = cell_zero[i] && in_list[i];
      if (cell_hit[i] && in_list[i]) begin
        hit_any = 1'b1;
        pos     = CNT_W'(i);
      end
    end
  end

  assign tail      = cnt - CNT_W'(1);
  assign full      = (cnt >= CNT_W'(LIST_ENTRIES));
  assign keep_pins = cell_pins[pos[IDX_W-1:0]];

  assign idx_c    = replacement_order ? (tail - scan_n) : scan_n;
  assign idx      = idx_c[IDX_W-1:0];
  assign scan_end = (scan_n >= cnt);
  assign cur_elig = elig[idx];

  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      if (elig[i] && (CNT_W'(i) > idx_c)) more_after = 1'b1;
    end
  end

  assign found_inc = found + CNT_W'(1);
  assign thr_hit   = (THR_W'({found_inc, 8'd0}) >= thresh);
  assign stop_one  = (cmd_q == lmv_pkg::CMD_PICK_ONE) || replacement_order || write_mode;
  // an LRU batch also ends at the last unpinned entry of the list
  assign vic_last  = stop_one || thr_hit || !more_after;
  assign out_free  = !out_valid || out_ready;

  logic is_scan;
  assign is_scan = (cmd_q == lmv_pkg::CMD_PICK_ONE) || (cmd_q == lmv_pkg::CMD_PICK_BAT);

  logic do_update;
  assign do_update = (state == S_EXEC) && !is_scan && out_free;

  // ---------------- per-cell control ----------------
  always_comb begin
    logic [15:0] new_pins;
    logic [CNT_W-1:0] ic;
    new_pins = 16'd0;
    case (cmd_q)
      lmv_pkg::CMD_TOUCH:   new_pins = hit_any ? keep_pins : 16'd0;
      lmv_pkg::CMD_SET_PIN: new_pins = pins_q;
      default:              new_pins = 16'd0;
    endcase
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      ic           = CNT_W'(i);
      ctrl[i].op   = lmv_pkg::CELL_HOLD;
      ctrl[i].page = page_q;
      ctrl[i].pins = new_pins;
      if (do_update) begin
        case (cmd_q)
          lmv_pkg::CMD_ADD: begin
            if (!full && ic == cnt) ctrl[i].op = lmv_pkg::CELL_LOAD;
          end
          lmv_pkg::CMD_TOUCH: begin
            if (hit_any) begin
              if (ic == tail) ctrl[i].op = lmv_pkg::CELL_LOAD;
              else if (ic >= pos && ic < tail) ctrl[i].op = lmv_pkg::CELL_SHIFT;
            end else if (!full && ic == cnt) begin
              ctrl[i].op = lmv_pkg::CELL_LOAD;
            end
          end
          lmv_pkg::CMD_REMOVE: begin
            if (hit_any && ic >= pos) ctrl[i].op = lmv_pkg::CELL_SHIFT;
          end
          lmv_pkg::CMD_SET_PIN: begin
            if (cell_hit[i] && in_list[i]) ctrl[i].op = lmv_pkg::CELL_PIN;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (do_update) begin
      case (cmd_q)
        lmv_pkg::CMD_ADD:    if (!full) cnt_next = cnt + CNT_W'(1);
        lmv_pkg::CMD_TOUCH:  if (!hit_any && !full) cnt_next = cnt + CNT_W'(1);
        lmv_pkg::CMD_REMOVE: if (hit_any) cnt_next = tail;
        default:             cnt_next = cnt;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (is_scan) state_next = S_SCAN;
        else if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (out_free && (scan_end || (cur_elig && vic_last))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (do_update || (state == S_SCAN && out_free && (scan_end || cur_elig))) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  logic [1:0] upd_status;
  always_comb begin
    upd_status = lmv_pkg::STAT_DONE;
    if ((cmd_q == lmv_pkg::CMD_ADD && full) ||
        (cmd_q == lmv_pkg::CMD_TOUCH && !hit_any && full)) begin
      upd_status = lmv_pkg::STAT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q  <= command;
      page_q <= page_id;
      pins_q <= pin_count;
    end
    if (state == S_EXEC && is_scan) begin
      scan_n <= '0;
      found  <= '0;
      thresh <= THR_W'(cnt) * THR_W'(9'd256 - {1'b0, keep_fraction});
    end
    if (do_update) begin
      victim_page <= page_q;
      status      <= upd_status;
      last        <= 1'b1;
    end
    if (state == S_SCAN) begin
      if (scan_end) begin
        if (out_free) begin
          victim_page <= page_q;
          status      <= lmv_pkg::STAT_NONE;
          last        <= 1'b1;
        end
      end else if (cur_elig) begin
        if (out_free) begin
          victim_page <= cell_page[idx];
          status      <= lmv_pkg::STAT_VICTIM;
          last        <= vic_last;
          found       <= found_inc;
          scan_n      <= scan_n + CNT_W'(1);
        end
      end else begin
        scan_n <= scan_n + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lmv_cell.sv */
// One list slot: holds a page id and its pin count, shifts from its upper neighbor.
`timescale 1ns / 1ps
`default_nettype none
module lmv_cell (
  input  wire logic                      clk,
  input  wire lmv_pkg::cell_ctrl_t       ctrl,
  input  wire logic [lmv_pkg::PAGE_W-1:0] nxt_page,
  input  wire logic [lmv_pkg::PIN_W-1:0]  nxt_pins,
  output logic [lmv_pkg::PAGE_W-1:0]      page,
  output logic [lmv_pkg::PIN_W-1:0]       pins,
  output logic                           hit,
  output logic                           zero
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      lmv_pkg::CELL_LOAD: begin
        page <= ctrl.page;
        pins <= ctrl.pins;
      end
      lmv_pkg::CELL_SHIFT: begin
        page <= nxt_page;
        pins <= nxt_pins;
      end
      lmv_pkg::CELL_PIN: begin
        pins <= ctrl.pins;
      end
      default: begin
      end
    endcase
  end

  // ctrl.page carries the key of the request under way
  assign hit  = (page == ctrl.page);
  assign zero = (pins == '0);

endmodule
`default_nettype wire

/* tb/sv/victim_list_checker.sv */
// Checker for the victim list: mirrors the page list, predicts each result and compares it.
`timescale 1ns / 1ps
module victim_list_checker
  import lmv_pkg::*;
#(
  parameter int LIST_ENTRIES = LIST_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        command,
  input  logic [PAGE_W-1:0] page_id,
  input  logic [PIN_W-1:0]  pin_count,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [PAGE_W-1:0] victim_page,
  input  logic [1:0]        status,
  input  logic              last,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [1:0]        code;
    logic              fin;
  } list_result_t;

  // mirror of the recency list, oldest at index 0
  logic [PAGE_W-1:0] page_list [LIST_ENTRIES];
  logic [PIN_W-1:0]  pin_list  [LIST_ENTRIES];
  int                list_len;
  logic              scan_mru;
  logic              one_per_batch;
  logic [7:0]        keep_frac;
  list_result_t      pending_results [$];

  function automatic void queue_result(input list_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int list_find(input logic [PAGE_W-1:0] pg);
    for (int i = 0; i < list_len; i++)
      if (page_list[i] == pg) return i;
    return -1;
  endfunction

  function automatic void list_drop(input int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      page_list[i] = page_list[i + 1];
      pin_list[i]  = pin_list[i + 1];
    end
    if (list_len > 0) list_len--;
  endfunction

  function automatic bit list_push(input logic [PAGE_W-1:0] pg, input logic [PIN_W-1:0] pn);
    if (list_len >= LIST_ENTRIES) return 1'b0;
    page_list[list_len] = pg;
    pin_list[list_len]  = pn;
    list_len++;
    return 1'b1;
  endfunction

  task automatic predict_results(input logic [2:0] cmd, input logic [PAGE_W-1:0] pg,
                                 input logic [PIN_W-1:0] pn);
    int                pos;
    int                idx;
    int                found;
    logic [1:0]        code;
    logic [PIN_W-1:0]  held;
    logic [PAGE_W-1:0] picked [LIST_ENTRIES];
    code = STAT_DONE;
    case (cmd)
      CMD_ADD: begin
        if (!list_push(pg, '0)) code = STAT_FULL;
      end
      CMD_TOUCH: begin
        pos = list_find(pg);
        if (pos >= 0) begin
          held = pin_list[pos];
          list_drop(pos);
          void'(list_push(pg, held));
        end else if (!list_push(pg, '0)) begin
          code = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        pos = list_find(pg);
        if (pos >= 0) list_drop(pos);
      end
      CMD_PICK_ONE, CMD_PICK_BAT: begin
        found = 0;
        for (int n = 0; n < list_len; n++) begin
          idx = scan_mru ? (list_len - 1 - n) : n;
          if (pin_list[idx] != '0) continue;
          picked[found] = page_list[idx];
          found++;
          if (cmd == CMD_PICK_ONE || scan_mru || one_per_batch) break;
          // exact integer keep threshold
          if (found * 256 >= list_len * (256 - int'(keep_frac))) break;
        end
        if (found == 0) begin
          queue_result('{pg, STAT_NONE, 1'b1});
        end else begin
          for (int i = 0; i < found; i++)
            queue_result('{picked[i], STAT_VICTIM, i == found - 1});
        end
        return;
      end
      CMD_SET_PIN: begin
        for (int i = 0; i < list_len; i++)
          if (page_list[i] == pg) pin_list[i] = pn;
      end
      default: ;
    endcase
    queue_result('{pg, code, 1'b1});
  endtask

  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (rst) begin
      list_len      = 0;
      scan_mru      = 1'b0;
      one_per_batch = 1'b0;
      keep_frac     = '0;
      fail_count    = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.page = victim_page;
        got.code = status;
        got.fin  = last;
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result page %h status %0d last %0b",
                     $time, got.page, got.code, got.fin);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch: page %h/%h status %0d/%0d last %0b/%0b (exp/act)",
                       $time, want.page, got.page, want.code, got.code, want.fin, got.fin);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORDER: scan_mru      = cfg_data[0];
          CFG_WMODE: one_per_batch = cfg_data[0];
          CFG_KEEP:  keep_frac     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_results(command, page_id, pin_count);
    end
    outstanding = pending_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Testbench top for the victim list: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 1ps
module testbench;
  import lmv_pkg::*;

  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int MIX_FILL    = 0;
  localparam int MIX_EVEN    = 1;
  localparam int MIX_SHRINK  = 2;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [2:0]  command   = '0;
  logic [31:0] page_id   = '0;
  logic [15:0] pin_count = '0;
  logic        out_ready = 1'b0;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] victim_page;
  logic [1:0]  status;
  logic        last;

  int          fail_count;
  int          outstanding;
  int          items_taken = 0;
  bit          quiet       = 1'b0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  logic [31:0] page_pool [16];

  // cumulative odds per mix for add, touch, remove, set pin, pick one, pick batch
  int          mix_cut [3][6] = '{'{50, 75, 78, 88, 92, 98},
                                  '{20, 40, 60, 75, 85, 97},
                                  '{5, 15, 60, 75, 85, 97}};
  logic [2:0]  mix_cmd [6] = '{CMD_ADD, CMD_TOUCH, CMD_REMOVE, CMD_SET_PIN,
                               CMD_PICK_ONE, CMD_PICK_BAT};

  lru_mru_victim_list uut (.*);
  victim_list_checker chk (.*);

  always #1 clk = ~clk;

  always @(posedge clk)
    if (in_valid && in_ready) items_taken <= items_taken + 1;

  // result side: random stalls, one long hold-off while requests keep coming
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_request(input logic [2:0] cmd, input logic [31:0] pg,
                              input logic [15:0] pn);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    page_id   <= pg;
    pin_count <= pn;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int mix);
    int          roll;
    logic [2:0]  cmd;
    logic [31:0] pg;
    logic [15:0] pn;
    roll = $urandom_range(99);
    cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    for (int c = 5; c >= 0; c--)
      if (roll < mix_cut[mix][c]) cmd = mix_cmd[c];
    // mostly a small pool so touch, remove and set pin find their page
    pg = ($urandom_range(99) < 85) ? page_pool[4'($urandom_range(15))] : $urandom;
    if (cmd == CMD_SET_PIN) begin
      case ($urandom_range(3))
        0, 1:    pn = '0;
        2:       pn = 16'($urandom_range(3, 1));
        default: pn = 16'($urandom_range(65535));
      endcase
    end else begin
      pn = 16'($urandom);
    end
    send_request(cmd, pg, pn);
  endtask

  task automatic run_phase(input logic order, input logic wmode, input logic [7:0] keep,
                           input int count, input int mix);
    settle_results();
    write_reg(CFG_ORDER, {7'd0, order});
    write_reg(CFG_WMODE, {7'd0, wmode});
    write_reg(CFG_KEEP, keep);
    repeat (count) send_random(mix);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) page_pool[i] = $urandom;
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, spare codes, duplicates, pinning, removal
    send_request(CMD_SPARE_LO, 32'h1234_5678, 16'h0000);
    send_request(CMD_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_PICK_ONE, 32'hA5A5_A5A5, 16'h0000);
    send_request(CMD_PICK_BAT, 32'h5A5A_5A5A, 16'h0000);
    send_request(CMD_REMOVE,   32'h0000_0001, 16'h0000);
    send_request(CMD_SET_PIN,  32'h0000_0001, 16'hFFFF);
    send_request(CMD_ADD,      32'h0000_0000, 16'h0000);
    send_request(CMD_ADD,      32'hFFFF_FFFF, 16'h0000);
    send_request(CMD_ADD,      32'h0000_0000, 16'h0000);
    send_request(CMD_TOUCH,    32'h0000_0000, 16'h0000);
    send_request(CMD_TOUCH,    32'h0000_BEEF, 16'h0000);
    send_request(CMD_SET_PIN,  32'h0000_0000, 16'hFFFF);
    send_request(CMD_PICK_ONE, 32'h0000_0000, 16'h0000);
    send_request(CMD_PICK_BAT, 32'h0000_0000, 16'h0000);
    send_request(CMD_SET_PIN,  32'hFFFF_FFFF, 16'h0001);
    send_request(CMD_SET_PIN,  32'h0000_BEEF, 16'h8000);
    send_request(CMD_PICK_ONE, 32'hDEAD_0001, 16'h0000);
    send_request(CMD_PICK_BAT, 32'hDEAD_0002, 16'h0000);
    send_request(CMD_SET_PIN,  32'h0000_0000, 16'h0000);
    send_request(CMD_REMOVE,   32'h0000_0000, 16'h0000);
    send_request(CMD_REMOVE,   32'h0000_0000, 16'h0000);
    send_request(CMD_REMOVE,   32'h0000_0000, 16'h0000);

    run_phase(1'b0, 1'b0, 8'd0,   80, MIX_FILL);
    run_phase(1'b0, 1'b0, 8'd128, 50, MIX_EVEN);
    quiet = 1'b1;
    run_phase(1'b1, 1'b0, 8'd0,   40, MIX_EVEN);
    quiet = 1'b0;
    run_phase(1'b0, 1'b1, 8'd0,   40, MIX_EVEN);
    run_phase(1'b0, 1'b0, 8'd255, 40, MIX_SHRINK);
    run_phase(1'b1, 1'b1, 8'd255, 40, MIX_FILL);
    run_phase(1'b0, 1'b0, 8'($urandom_range(255)), 45, MIX_EVEN);
    run_phase(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
              45, MIX_SHRINK);

    settle_results();
    repeat (2 * LIST_ENTRIES_DEF + 10) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
